### hw/rtl/gcd_pkg.sv
package gcd_pkg;

  // Channel payloads
  typedef struct packed {
    logic signed [30:0] target_latitude;
    logic signed [31:0] target_longitude;
  } gcd_in_t;

  typedef struct packed {
    logic [30:0] distance_cm;
    logic [15:0] bearing_centideg;
  } gcd_out_t;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_LAT = 2'd0,
    CFG_REF_LON = 2'd1
  } gcd_cfg_e;

  localparam logic [30:0] RefLatReset = 31'd423071020;
  localparam logic [31:0] RefLonReset = 32'd3578840666;  // -716126630

  // Degree-to-binary-angle scaling: q = (m * 2^21 + DivBias) / DivDen, where m is
  // the magnitude (half angle) or twice it (full angle). The quotient comes from
  // a reciprocal multiply: q = (m * RecipA + RecipC) >> RecipShift, exact for
  // m < 2^33 because both constants are rounded up and the overshoot stays
  // below 1 / DivDen.
  localparam int unsigned DivMagW    = 33;
  localparam int unsigned DivQuoW    = 34;
  localparam int unsigned DivSteps   = 2;
  localparam int unsigned RecipShift = 55;
  localparam logic [21:0] DivDen     = 22'd3515625;
  localparam logic [20:0] DivBias    = 21'd1757812;
  localparam logic [54:0] RecipA     =
    55'(((77'd1 << (RecipShift + 21)) + 77'(DivDen) - 77'd1) / 77'(DivDen));
  localparam logic [54:0] RecipC     =
    55'(((77'(DivBias) << RecipShift) + 77'(DivDen) - 77'd1) / 77'(DivDen));

  typedef struct packed {
    logic               neg;
    logic [DivMagW-1:0] mag;
    logic [DivQuoW-1:0] quo;
  } gcd_div_t;

  // CORDIC datapath
  localparam int unsigned CordW = 35;
  localparam int unsigned AngW  = 34;
  localparam logic [CordW-1:0] CordicGainInv = 35'd652032874;

  typedef struct packed {
    logic [CordW-1:0] x;
    logic [CordW-1:0] y;
    logic [AngW-1:0]  z;
    logic             flip;
  } gcd_cord_t;

  // Integer square root, one result bit per step
  localparam int unsigned SqrtW     = 62;
  localparam int unsigned SqrtSteps = 31;

  typedef struct packed {
    logic [SqrtW-1:0] v;
    logic [SqrtW-1:0] r;
  } gcd_sqrt_t;

  // Bearing vector carried alongside the square roots
  typedef struct packed {
    logic [CordW-1:0] x;
    logic [CordW-1:0] y;
    logic             off;
    logic             zero;
  } gcd_brg_t;

  localparam logic [30:0] PiRadiusCm = 31'd2001508680;
  localparam logic [15:0] CentiTurn  = 16'd36000;

  // atan(2^-i) in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_bam(input int unsigned i);
    logic [31:0] res;
    case (i)
      0:  res = 32'd536870912;
      1:  res = 32'd316933406;
      2:  res = 32'd167458907;
      3:  res = 32'd85004756;
      4:  res = 32'd42667331;
      5:  res = 32'd21354465;
      6:  res = 32'd10679838;
      7:  res = 32'd5340245;
      8:  res = 32'd2670163;
      9:  res = 32'd1335087;
      10: res = 32'd667544;
      11: res = 32'd333772;
      12: res = 32'd166886;
      13: res = 32'd83443;
      14: res = 32'd41722;
      15: res = 32'd20861;
      16: res = 32'd10430;
      17: res = 32'd5215;
      18: res = 32'd2608;
      19: res = 32'd1304;
      20: res = 32'd652;
      21: res = 32'd326;
      22: res = 32'd163;
      23: res = 32'd81;
      24: res = 32'd41;
      25: res = 32'd20;
      26: res = 32'd10;
      27: res = 32'd5;
      28: res = 32'd3;
      29: res = 32'd1;
      30: res = 32'd1;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/great_circle_distance_bearing.sv
// Great-circle distance and initial bearing from a configured reference point.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one target position per
// beat, latitude and longitude in 1e-7 degree. Output channel (out_valid_o /
// out_stall_i / out_data_o): one beat per input beat, in order, carrying the
// haversine distance in cm and the initial bearing in 0.01 degree.
// Configuration: cfg_we_i writes cfg_data_i to the register chosen by
// cfg_idx_i (0 reference latitude, 1 reference longitude); other indexes are
// ignored. Write only while no beat is in flight.
//
// The chain holds 2 input stages, 2 reciprocal multiply stages, 1 setup stage,
// CORDIC_STEPS rotation cells, 4 multiply stages, 31 square-root cells,
// CORDIC_STEPS vectoring cells and 2 output stages. Throughput is one beat per
// cycle while out_stall_i holds back no result; every stage is a register in a
// single chain, so the depth of the cell chains sets the latency only.
// When out_stall_i holds back a valid result, the whole chain freezes and
// in_stall_o is raised in the same cycle; nothing is dropped.
// Reset clears all stage valid bits and loads the reset reference point.
module great_circle_distance_bearing #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  gcd_pkg::gcd_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output gcd_pkg::gcd_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [gcd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [gcd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import gcd_pkg::*;

  localparam int unsigned NumAng   = 5;
  localparam int unsigned AngLat1  = 0;
  localparam int unsigned AngLat2  = 1;
  localparam int unsigned AngDLatH = 2;
  localparam int unsigned AngDLonH = 3;
  localparam int unsigned AngDLon  = 4;
  localparam int unsigned SqA      = 0;
  localparam int unsigned SqB      = 1;
  localparam int unsigned VecDist  = 0;
  localparam int unsigned VecBrg   = 1;
  localparam int unsigned Lat      = 42 + 2 * CORDIC_STEPS;
  localparam int unsigned D4Idx    = DivSteps + CORDIC_STEPS + 6;

  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AngW-1:0] HalfTurn    = 34'sd2147483648;
  localparam logic [60:0]            OneQ60      = 61'h1000_0000_0000_0000;

  logic            en;
  logic [Lat-1:0]  vld_q;
  logic [30:0]     ref_lat_q;
  logic [31:0]     ref_lon_q;

  // ---- flow control: the whole chain advances unless the output is held
  assign en          = ~(out_valid_o & out_stall_i);
  assign in_stall_o  = ~en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= RefLatReset;
      ref_lon_q <= RefLonReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_LAT: ref_lat_q <= cfg_data_i[30:0];
        CFG_REF_LON: ref_lon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- A0: extend and take differences
  logic signed [32:0] ang_d [NumAng];
  logic signed [32:0] ang_q [NumAng];
  logic signed [32:0] lat1, lat2, lon1, lon2, dlon;

  always_comb begin
    lat1 = {{2{ref_lat_q[30]}}, ref_lat_q};
    lat2 = {{2{in_data_i.target_latitude[30]}}, in_data_i.target_latitude};
    lon1 = {ref_lon_q[31], ref_lon_q};
    lon2 = {in_data_i.target_longitude[31], in_data_i.target_longitude};
    dlon = lon2 - lon1;
    ang_d[AngLat1]  = lat1;
    ang_d[AngLat2]  = lat2;
    ang_d[AngDLatH] = lat2 - lat1;
    ang_d[AngDLonH] = dlon;
    ang_d[AngDLon]  = dlon;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q <= ang_d;
    end
  end

  // ---- A1, reciprocal scaling, setup and rotation chains, one per angle
  gcd_div_t        div_in_q  [NumAng];
  gcd_div_t        div_c     [NumAng];
  gcd_cord_t       cord_in_q [NumAng];
  gcd_cord_t       cord_c    [NumAng][CORDIC_STEPS+1];
  logic signed [31:0] sin_w  [NumAng];
  logic signed [31:0] cos_w  [NumAng];

  for (genvar k = 0; k < NumAng; k++) begin : g_ang
    localparam bit IsHalf = (k == AngDLatH) || (k == AngDLonH);

    logic [32:0]          mag;
    gcd_div_t             div_d;
    logic [31:0]          bam;
    logic signed [AngW-1:0] zs;
    gcd_cord_t            cord_d;
    gcd_cord_t            fin;
    logic [CordW-1:0]     xo, yo;

    // magnitude, doubled for a full angle (differences stay below 2^32)
    always_comb begin
      mag       = ang_q[k][32] ? 33'(-ang_q[k]) : ang_q[k];
      div_d.neg = ang_q[k][32];
      div_d.mag = IsHalf ? mag : {mag[31:0], 1'b0};
      div_d.quo = '0;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_in_q[k] <= div_d;
      end
    end

    gcd_div_cell u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (div_in_q[k]),
      .d_o   (div_c[k])
    );

    // fold into the right half-plane, start vector on the x axis
    always_comb begin
      bam = div_c[k].neg ? (32'd0 - div_c[k].quo[31:0]) : div_c[k].quo[31:0];
      zs  = {{2{bam[31]}}, bam};
      cord_d.x    = CordicGainInv;
      cord_d.y    = '0;
      cord_d.z    = zs;
      cord_d.flip = 1'b0;
      if (zs > QuarterTurn) begin
        cord_d.z    = zs - HalfTurn;
        cord_d.flip = 1'b1;
      end else if (zs < -QuarterTurn) begin
        cord_d.z    = zs + HalfTurn;
        cord_d.flip = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cord_in_q[k] <= cord_d;
      end
    end

    assign cord_c[k][0] = cord_in_q[k];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      gcd_cordic_cell #(
        .STEP (i),
        .VEC  (1'b0)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .c_i   (cord_c[k][i]),
        .c_o   (cord_c[k][i+1])
      );
    end

    // undo the half-turn fold
    always_comb begin
      fin      = cord_c[k][CORDIC_STEPS];
      xo       = fin.flip ? -fin.x : fin.x;
      yo       = fin.flip ? -fin.y : fin.y;
      cos_w[k] = xo[31:0];
      sin_w[k] = yo[31:0];
    end
  end

  // ---- D1: first products
  logic signed [63:0] pt_q, pe_q, pp_q, pq_q, phh_q;
  logic signed [31:0] sd1_q, cdl1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q   <= cos_w[AngLat1] * cos_w[AngLat2];
      pe_q   <= sin_w[AngDLon] * cos_w[AngLat2];
      pp_q   <= sin_w[AngLat1] * cos_w[AngLat2];
      pq_q   <= cos_w[AngLat1] * sin_w[AngLat2];
      phh_q  <= sin_w[AngDLatH] * sin_w[AngDLatH];
      sd1_q  <= sin_w[AngDLonH];
      cdl1_q <= cos_w[AngDLon];
    end
  end

  // ---- D2: rescale and second products
  logic signed [63:0] ut_q, pr_q, pq2_q, phh2_q;
  logic signed [33:0] e2_q;
  logic signed [31:0] sd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ut_q   <= $signed(pt_q[63:30]) * sd1_q;
      pr_q   <= $signed(pp_q[63:30]) * cdl1_q;
      e2_q   <= $signed(pe_q[63:30]);
      pq2_q  <= pq_q;
      phh2_q <= phh_q;
      sd2_q  <= sd1_q;
    end
  end

  // ---- D3: cross term product and bearing north component
  logic signed [63:0] mu_q, phh3_q, ndiff;
  logic signed [33:0] n3_q, e3_q;

  assign ndiff = pq2_q - pr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_q   <= $signed(ut_q[63:30]) * sd2_q;
      n3_q   <= $signed(ndiff[63:30]);
      e3_q   <= e2_q;
      phh3_q <= phh2_q;
    end
  end

  // ---- D4: clamp haversine term, fold bearing vector into x >= 0
  logic signed [63:0] asum;
  logic [60:0]        a_d, a_q, b_q;
  gcd_brg_t           brg_d, brg_q;
  logic [CordW-1:0]   nx, ey;

  always_comb begin
    asum = phh3_q + mu_q;
    if (asum[63]) begin
      a_d = '0;
    end else if (asum > $signed({3'b000, OneQ60})) begin
      a_d = OneQ60;
    end else begin
      a_d = asum[60:0];
    end
    nx         = {n3_q[33], n3_q};
    ey         = {e3_q[33], e3_q};
    brg_d.zero = (n3_q == '0) && (e3_q == '0);
    brg_d.off  = n3_q[33];
    brg_d.x    = n3_q[33] ? -nx : nx;
    brg_d.y    = n3_q[33] ? -ey : ey;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= OneQ60 - a_d;
      brg_q <= brg_d;
    end
  end

  // ---- square-root chains
  gcd_sqrt_t sq_c [2][SqrtSteps+1];

  assign sq_c[SqA][0] = '{v: {1'b0, a_q}, r: '0};
  assign sq_c[SqB][0] = '{v: {1'b0, b_q}, r: '0};

  for (genvar m = 0; m < 2; m++) begin : g_sq
    for (genvar j = 0; j < SqrtSteps; j++) begin : g_cell
      gcd_sqrt_cell #(
        .K (SqrtSteps - 1 - j)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .s_i   (sq_c[m][j]),
        .s_o   (sq_c[m][j+1])
      );
    end
  end

  gcd_brg_t brg_w;

  gcd_delay #(
    .WIDTH ($bits(gcd_brg_t)),
    .DEPTH (SqrtSteps)
  ) u_brg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (brg_q),
    .d_o   (brg_w)
  );

  // ---- vectoring chains: central half angle and bearing
  gcd_cord_t vec_c [2][CORDIC_STEPS+1];

  assign vec_c[VecDist][0] = '{x: {4'b0000, sq_c[SqB][SqrtSteps].r[30:0]},
                               y: {4'b0000, sq_c[SqA][SqrtSteps].r[30:0]},
                               z: '0, flip: 1'b0};
  assign vec_c[VecBrg][0]  = '{x: brg_w.x, y: brg_w.y, z: '0, flip: 1'b0};

  for (genvar m = 0; m < 2; m++) begin : g_vec
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      gcd_cordic_cell #(
        .STEP (i),
        .VEC  (1'b1)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .c_i   (vec_c[m][i]),
        .c_o   (vec_c[m][i+1])
      );
    end
  end

  logic [1:0] flg_w;

  gcd_delay #(
    .WIDTH (2),
    .DEPTH (CORDIC_STEPS)
  ) u_flg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({brg_w.off, brg_w.zero}),
    .d_o   (flg_w)
  );

  // ---- G1: clamp angle and scale both results
  logic signed [AngW-1:0] zd;
  logic [30:0]            zc;
  logic [31:0]            bam_b;
  logic [61:0]            dm_q;
  logic [47:0]            cm_q;
  logic                   zero_q;

  always_comb begin
    zd = vec_c[VecDist][CORDIC_STEPS].z;
    if (zd[AngW-1]) begin
      zc = '0;
    end else if (zd > QuarterTurn) begin
      zc = QuarterTurn[30:0];
    end else begin
      zc = zd[30:0];
    end
    bam_b = vec_c[VecBrg][CORDIC_STEPS].z[31:0] + {flg_w[1], 31'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q   <= {31'd0, zc} * {31'd0, PiRadiusCm};
      cm_q   <= {16'd0, bam_b} * {32'd0, CentiTurn};
      zero_q <= flg_w[0];
    end
  end

  // ---- G2: round and register the result beat
  logic [62:0] dsum;
  logic [48:0] csum;
  gcd_out_t    out_d, out_q;

  always_comb begin
    dsum              = {1'b0, dm_q} + 63'h2000_0000;
    csum              = {1'b0, cm_q} + 49'h8000_0000;
    out_d.distance_cm = dsum[60:30];
    if (zero_q || (csum[48:32] >= {1'b0, CentiTurn})) begin
      out_d.bearing_centideg = '0;
    end else begin
      out_d.bearing_centideg = csum[47:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---- assertions
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q))
    else $error("pipeline moved while result held");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && !in_stall_o |=> vld_q[0] == $past(in_valid_i))
    else $error("accepted beat not tracked");

  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[D4Idx] |-> ({1'b0, a_q} + {1'b0, b_q}) == {1'b0, OneQ60})
    else $error("haversine split does not sum to one");

  a_brg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bearing_centideg < CentiTurn)
    else $error("bearing out of range");

  a_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.distance_cm <= PiRadiusCm)
    else $error("distance beyond half circumference");

endmodule

### hw/rtl/gcd_div_cell.sv
module gcd_div_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  gcd_pkg::gcd_div_t d_i,
  output gcd_pkg::gcd_div_t d_o
);
  import gcd_pkg::*;

  localparam logic [31:0] RecipLo = RecipA[31:0];
  localparam logic [22:0] RecipHi = RecipA[54:32];

  logic [64:0] plo_q;
  logic [55:0] phi_q;
  logic        neg_q;
  logic [88:0] sum;
  gcd_div_t    div_d, div_q;

  // stage 1: reciprocal product split into two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= {32'd0, d_i.mag} * {33'd0, RecipLo};
      phi_q <= {23'd0, d_i.mag} * {33'd0, RecipHi};
      neg_q <= d_i.neg;
    end
  end

  // stage 2: recombine, add the rounding constant, keep the quotient bits
  always_comb begin
    sum       = {1'b0, phi_q, 32'd0} + {24'd0, plo_q} + {34'd0, RecipC};
    div_d.neg = neg_q;
    div_d.mag = '0;
    div_d.quo = sum[88:RecipShift];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign d_o = div_q;

endmodule

### hw/rtl/gcd_cordic_cell.sv
module gcd_cordic_cell #(
  parameter int unsigned STEP = 0,
  parameter bit          VEC  = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  gcd_pkg::gcd_cord_t c_i,
  output gcd_pkg::gcd_cord_t c_o
);
  import gcd_pkg::*;

  localparam logic [AngW-1:0] Atan = {2'b00, atan_bam(STEP)};

  logic signed [CordW-1:0] xs, ys;
  logic                    up;
  gcd_cord_t               c_d, c_q;

  // rotate toward z = 0 (rotation) or toward y = 0 (vectoring)
  always_comb begin
    xs  = $signed(c_i.x) >>> STEP;
    ys  = $signed(c_i.y) >>> STEP;
    up  = VEC ? c_i.y[CordW-1] : ~c_i.z[AngW-1];
    c_d = c_i;
    if (up) begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - Atan;
    end else begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

### hw/rtl/gcd_sqrt_cell.sv
module gcd_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  gcd_pkg::gcd_sqrt_t s_i,
  output gcd_pkg::gcd_sqrt_t s_o
);
  import gcd_pkg::*;

  localparam logic [SqrtW-1:0] Bit = {{(SqrtW-1){1'b0}}, 1'b1} << (2 * K);

  logic [SqrtW-1:0] sum;
  gcd_sqrt_t        s_d, s_q;

  // one result bit: try r + 4^K against the remainder
  always_comb begin
    sum = s_i.r + Bit;
    s_d = s_i;
    if (s_i.v >= sum) begin
      s_d.v = s_i.v - sum;
      s_d.r = (s_i.r >> 1) + Bit;
    end else begin
      s_d.r = s_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

### hw/rtl/gcd_delay.sv
module gcd_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  // shift line that advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        stage_q[i] <= stage_q[i-1];
      end
    end
  end

  assign d_o = stage_q[DEPTH-1];

endmodule
